// ----- hw/rtl/icer_pkg.sv -----
package icer_pkg;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       last_in;
	} req_t;

	typedef struct packed {
		logic       out_kind;
		logic [2:0] verdict;
		logic [7:0] out_byte;
		logic       out_last;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_LOAD_LAST,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FOLD,
		BK_CSUM,
		BK_READ
	} bk_state_t;

	// request opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result kinds
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_BYTE    = 1'b1;

	// verdict codes
	localparam logic [2:0] VD_REPLY      = 3'd0;
	localparam logic [2:0] VD_BAD_CODE   = 3'd1;
	localparam logic [2:0] VD_ECHO_REPLY = 3'd2;
	localparam logic [2:0] VD_UNKNOWN    = 3'd3;
	localparam logic [2:0] VD_MALFORMED  = 3'd4;

	// frame layout (byte offsets)
	localparam int OFS_SRC_MAC  = 6;
	localparam int OFS_ETYPE    = 12;
	localparam int OFS_PLEN_HI  = 18;
	localparam int OFS_PLEN_LO  = 19;
	localparam int OFS_SRC_ADDR = 22;
	localparam int OFS_DST_ADDR = 38;
	localparam int ADDR_BYTES   = 16;
	localparam int OFS_TYPE     = 54;
	localparam int OFS_CODE     = 55;
	localparam int OFS_CKS_HI   = 56;
	localparam int OFS_CKS_LO   = 57;
	localparam int MIN_FRAME    = 62;
	localparam int MIN_PLEN     = 8;

	localparam logic [7:0]  TYPE_ECHO_REQ = 8'd128;
	localparam logic [7:0]  TYPE_ECHO_REP = 8'd129;
	localparam logic [15:0] NH_ICMPV6     = 16'd58;

endpackage

// ----- hw/rtl/icer_ram.sv -----
module icer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/icer_front.sv -----
module icer_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  icer_pkg::req_t  req,
	output logic            busy,
	input  logic            pop,
	output logic            q_valid,
	output icer_pkg::cmd_t  q_cmd
);

	icer_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           do_pop;
	icer_pkg::cmd_t cmd_in;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign do_pop  = pop && q_valid;
	assign q_cmd   = fifo_q[rd_ptr_q];

	// decode the request into a back-end command
	always_comb begin
		cmd_in.data = req.data_byte;
		if (req.opcode == icer_pkg::OP_READ) begin
			cmd_in.kind = icer_pkg::CMD_READ;
		end else if (req.last_in) begin
			cmd_in.kind = icer_pkg::CMD_LOAD_LAST;
		end else begin
			cmd_in.kind = icer_pkg::CMD_LOAD;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/icer_back.sv -----
module icer_back #(
	parameter int FRAME_BYTES = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  icer_pkg::cmd_t                 q_cmd,
	output logic                           pop,
	input  logic [47:0]                    own_mac,
	output logic                           ram_we,
	output logic [$clog2(FRAME_BYTES)-1:0] ram_waddr,
	output logic [7:0]                     ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr,
	input  logic [7:0]                     ram_rdata,
	output logic                           rsp_valid,
	output icer_pkg::rsp_t                 rsp
);

	localparam int AW  = $clog2(FRAME_BYTES);
	localparam int LCW = $clog2(FRAME_BYTES + 2);
	// compare width: holds 54 + 16-bit length and any byte count
	localparam int CW  = 18;

	icer_pkg::bk_state_t state_q, state_d;

	logic [LCW-1:0] lc_q;
	logic [LCW-1:0] ri_q;
	logic [31:0]    sum_q;
	logic [15:0]    plen_q;
	logic [7:0]     type_q;
	logic [7:0]     code_q;
	logic [15:0]    cks_q;
	logic [15:0]    fold_q;
	logic           ready_q;
	logic           closed_q;

	logic           rd_use_ram_s1;
	logic [7:0]     rd_fix_s1;
	logic           rd_last_s1;

	logic           rsp_valid_q;
	icer_pkg::rsp_t rsp_q;

	// control decode
	logic is_load, is_last, is_read;
	logic do_load, do_read, do_fold, do_csum, do_emit;

	// load datapath
	logic [LCW-1:0] lc_base, lc_new;
	logic [31:0]    sum_base, sum_new;
	logic [15:0]    plen_base, plen_new;
	logic [7:0]     type_base, type_new, code_base, code_new;
	logic           in_range, sum_hit, malformed;
	logic [7:0]     sv;
	logic [2:0]     verdict;

	// read datapath
	logic           rd_ok, rd_last;
	logic [LCW-1:0] rd_addr;
	logic           rd_use_ram;
	logic [7:0]     rd_fix;
	logic [2:0]     mac_k;

	// checksum datapath
	logic [16:0] f0;
	logic [17:0] s1;
	logic [16:0] f1;
	logic [15:0] f2;

	always_comb begin
		is_load = 1'b0;
		is_last = 1'b0;
		is_read = 1'b0;
		unique case (q_cmd.kind)
			icer_pkg::CMD_LOAD: begin
				is_load = 1'b1;
			end
			icer_pkg::CMD_LOAD_LAST: begin
				is_load = 1'b1;
				is_last = 1'b1;
			end
			icer_pkg::CMD_READ: begin
				is_read = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ---- load and classify ----
	always_comb begin
		lc_base   = closed_q ? '0 : lc_q;
		sum_base  = closed_q ? '0 : sum_q;
		plen_base = closed_q ? '0 : plen_q;
		type_base = closed_q ? '0 : type_q;
		code_base = closed_q ? '0 : code_q;
		in_range  = (lc_base < LCW'(FRAME_BYTES));

		plen_new = plen_base;
		type_new = type_base;
		code_new = code_base;
		if (in_range) begin
			if (lc_base == LCW'(icer_pkg::OFS_PLEN_HI)) begin
				plen_new = {q_cmd.data, plen_base[7:0]};
			end else if (lc_base == LCW'(icer_pkg::OFS_PLEN_LO)) begin
				plen_new = {plen_base[15:8], q_cmd.data};
			end else if (lc_base == LCW'(icer_pkg::OFS_TYPE)) begin
				type_new = q_cmd.data;
			end else if (lc_base == LCW'(icer_pkg::OFS_CODE)) begin
				code_new = q_cmd.data;
			end
		end

		// pseudo-header addresses plus the ICMPv6 message
		sum_hit = in_range && (lc_base >= LCW'(icer_pkg::OFS_SRC_ADDR)) &&
			((lc_base < LCW'(icer_pkg::OFS_TYPE)) ||
			 (CW'(lc_base) < CW'(icer_pkg::OFS_TYPE) + CW'(plen_new)));

		if (lc_base == LCW'(icer_pkg::OFS_TYPE)) begin
			sv = icer_pkg::TYPE_ECHO_REP;
		end else if (lc_base == LCW'(icer_pkg::OFS_CKS_HI) ||
			lc_base == LCW'(icer_pkg::OFS_CKS_LO)) begin
			sv = 8'd0;
		end else begin
			sv = q_cmd.data;
		end

		if (!sum_hit) begin
			sum_new = sum_base;
		end else if (lc_base[0]) begin
			sum_new = sum_base + {24'd0, sv};
		end else begin
			sum_new = sum_base + {16'd0, sv, 8'd0};
		end

		lc_new = in_range ? lc_base + LCW'(1) : LCW'(FRAME_BYTES + 1);

		malformed = (lc_new > LCW'(FRAME_BYTES)) ||
			(lc_new < LCW'(icer_pkg::MIN_FRAME)) ||
			(plen_new < 16'(icer_pkg::MIN_PLEN)) ||
			(CW'(icer_pkg::OFS_TYPE) + CW'(plen_new) > CW'(lc_new));

		priority if (malformed) begin
			verdict = icer_pkg::VD_MALFORMED;
		end else if (type_new == icer_pkg::TYPE_ECHO_REQ) begin
			verdict = (code_new != 8'd0) ? icer_pkg::VD_BAD_CODE : icer_pkg::VD_REPLY;
		end else if (type_new == icer_pkg::TYPE_ECHO_REP) begin
			verdict = icer_pkg::VD_ECHO_REPLY;
		end else begin
			verdict = icer_pkg::VD_UNKNOWN;
		end
	end

	// ---- reply byte mapping ----
	always_comb begin
		rd_ok   = ready_q && (ri_q < lc_q) && (ri_q < LCW'(FRAME_BYTES));
		rd_last = (CW'(ri_q) + CW'(1) >= CW'(lc_q));
		mac_k   = 3'(ri_q - LCW'(icer_pkg::OFS_SRC_MAC));

		rd_use_ram = 1'b1;
		rd_fix     = 8'd0;
		rd_addr    = ri_q;
		if (ri_q < LCW'(icer_pkg::OFS_SRC_MAC)) begin
			rd_addr = ri_q + LCW'(icer_pkg::OFS_SRC_MAC);
		end else if (ri_q < LCW'(icer_pkg::OFS_ETYPE)) begin
			rd_use_ram = 1'b0;
			rd_fix     = own_mac[8 * (3'd5 - mac_k) +: 8];
		end else if (ri_q >= LCW'(icer_pkg::OFS_SRC_ADDR) &&
			ri_q < LCW'(icer_pkg::OFS_DST_ADDR)) begin
			rd_addr = ri_q + LCW'(icer_pkg::ADDR_BYTES);
		end else if (ri_q >= LCW'(icer_pkg::OFS_DST_ADDR) &&
			ri_q < LCW'(icer_pkg::OFS_TYPE)) begin
			rd_addr = ri_q - LCW'(icer_pkg::ADDR_BYTES);
		end else if (ri_q == LCW'(icer_pkg::OFS_TYPE)) begin
			rd_use_ram = 1'b0;
			rd_fix     = icer_pkg::TYPE_ECHO_REP;
		end else if (ri_q == LCW'(icer_pkg::OFS_CKS_HI)) begin
			rd_use_ram = 1'b0;
			rd_fix     = cks_q[15:8];
		end else if (ri_q == LCW'(icer_pkg::OFS_CKS_LO)) begin
			rd_use_ram = 1'b0;
			rd_fix     = cks_q[7:0];
		end
	end

	// ---- checksum folding, split over the FOLD and CSUM states ----
	always_comb begin
		f0 = {1'b0, sum_q[15:0]} + {1'b0, sum_q[31:16]};
		s1 = {2'd0, fold_q} + {2'd0, plen_q} + {2'd0, icer_pkg::NH_ICMPV6};
		f1 = {1'b0, s1[15:0]} + {15'd0, s1[17:16]};
		f2 = f1[15:0] + {15'd0, f1[16]};
	end

	// ---- control ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icer_pkg::BK_IDLE: begin
				if (q_valid && is_last && verdict == icer_pkg::VD_REPLY) begin
					state_d = icer_pkg::BK_FOLD;
				end else if (q_valid && is_read && rd_ok) begin
					state_d = icer_pkg::BK_READ;
				end
			end
			icer_pkg::BK_FOLD: state_d = icer_pkg::BK_CSUM;
			icer_pkg::BK_CSUM: state_d = icer_pkg::BK_IDLE;
			icer_pkg::BK_READ: state_d = icer_pkg::BK_IDLE;
			default: state_d = icer_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		do_load = 1'b0;
		do_read = 1'b0;
		do_fold = 1'b0;
		do_csum = 1'b0;
		do_emit = 1'b0;
		unique case (state_q)
			icer_pkg::BK_IDLE: begin
				pop     = q_valid;
				do_load = q_valid && is_load;
				do_read = q_valid && is_read && rd_ok;
			end
			icer_pkg::BK_FOLD: do_fold = 1'b1;
			icer_pkg::BK_CSUM: do_csum = 1'b1;
			icer_pkg::BK_READ: do_emit = 1'b1;
			default: begin
			end
		endcase
	end

	assign ram_we    = do_load && in_range;
	assign ram_waddr = lc_base[AW-1:0];
	assign ram_wdata = q_cmd.data;
	assign ram_re    = do_read;
	assign ram_raddr = rd_addr[AW-1:0];

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= icer_pkg::BK_IDLE;
			lc_q        <= '0;
			ri_q        <= '0;
			sum_q       <= '0;
			plen_q      <= '0;
			type_q      <= '0;
			code_q      <= '0;
			cks_q       <= '0;
			fold_q      <= '0;
			ready_q     <= 1'b0;
			closed_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= 1'b0;
			if (do_load) begin
				lc_q     <= lc_new;
				sum_q    <= sum_new;
				plen_q   <= plen_new;
				type_q   <= type_new;
				code_q   <= code_new;
				ready_q  <= 1'b0;
				ri_q     <= '0;
				closed_q <= is_last;
				if (closed_q) begin
					cks_q <= '0;
				end
				if (is_last) begin
					rsp_valid_q <= 1'b1;
				end
			end
			if (do_read) begin
				ri_q <= ri_q + LCW'(1);
				if (rd_last) begin
					ready_q <= 1'b0;
				end
			end
			if (do_fold) begin
				fold_q <= f0[15:0] + {15'd0, f0[16]};
			end
			if (do_csum) begin
				cks_q   <= ~f2;
				ready_q <= 1'b1;
			end
			if (do_emit) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_use_ram_s1 <= rd_use_ram;
			rd_fix_s1     <= rd_fix;
			rd_last_s1    <= rd_last;
		end
		if (do_load && is_last) begin
			rsp_q <= '{out_kind: icer_pkg::KIND_VERDICT, verdict: verdict,
				out_byte: 8'd0, out_last: 1'b0};
		end else if (do_emit) begin
			rsp_q <= '{out_kind: icer_pkg::KIND_BYTE, verdict: icer_pkg::VD_REPLY,
				out_byte: rd_use_ram_s1 ? ram_rdata : rd_fix_s1,
				out_last: rd_last_s1};
		end
	end

endmodule

// ----- hw/rtl/icmpv6_echo_responder.sv -----
// ICMPv6 echo responder. Requests enter through start/busy into a two-entry
// command queue and are executed in order by the back end; busy is high only
// while that queue is full. Loads stream at one byte per cycle while the back
// end is idle. The load that carries last_in yields a registered verdict in
// the following cycle; on a reply verdict the back end then folds the checksum
// in its FOLD and CSUM states before it takes the next request. A reply-byte
// read passes through the IDLE and READ states (the frame buffer has a
// registered read port), so the next request waits until the byte is out. A
// read with no reply pending, or past the end of the reply, gives no result.
// Results appear on rsp for exactly one cycle with rsp_valid high and cannot
// be held off. own_mac may be written only while the block is idle.
module icmpv6_echo_responder #(
	parameter int FRAME_BYTES = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  icer_pkg::req_t       req,
	output logic                 busy,
	output logic                 rsp_valid,
	output icer_pkg::rsp_t       rsp,
	input  logic                 own_mac_we,
	input  logic [47:0]          own_mac_wdata
);

	localparam int AW = $clog2(FRAME_BYTES);

	logic [47:0]    own_mac_q;
	logic           pop;
	logic           q_valid;
	icer_pkg::cmd_t q_cmd;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
		end else if (own_mac_we) begin
			own_mac_q <= own_mac_wdata;
		end
	end

	icer_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	icer_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	icer_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.own_mac   (own_mac_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- sim/icer_sb_pkg.sv -----
`timescale 1ns / 100ps
package icer_sb_pkg;
	import icer_pkg::*;

	localparam int unsigned STORE_BYTES = 2048;
	localparam int unsigned REPORT_MAX  = 10;

	class echo_scoreboard;
		logic [7:0]  frame_mem [STORE_BYTES];
		int unsigned n_loaded;
		int unsigned rd_pos;
		logic [31:0] csum_acc;
		logic [15:0] plen;
		logic [7:0]  msg_type;
		logic [7:0]  msg_code;
		logic [15:0] reply_csum;
		bit          reply_pending;
		bit          frame_done;
		logic [47:0] mac;
		rsp_t        pending[$];
		int unsigned n_errors;
		int unsigned n_verdicts;

		function new();
			n_loaded      = 0;
			rd_pos        = 0;
			csum_acc      = '0;
			plen          = '0;
			msg_type      = '0;
			msg_code      = '0;
			reply_csum    = '0;
			reply_pending = 1'b0;
			frame_done    = 1'b0;
			mac           = '0;
			n_errors      = 0;
			n_verdicts    = 0;
		endfunction

		function void set_mac(logic [47:0] value);
			mac = value;
		endfunction

		function logic [15:0] fold16(logic [31:0] s);
			s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
			s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
			return s[15:0];
		endfunction

		// byte i of the echo reply built from the stored request
		function logic [7:0] reply_at(int unsigned i);
			if (i < OFS_SRC_MAC)
				return frame_mem[i + OFS_SRC_MAC];
			if (i < OFS_ETYPE)
				return 8'(mac >> (8 * (11 - i)));
			if (i >= OFS_SRC_ADDR && i < OFS_DST_ADDR)
				return frame_mem[i + ADDR_BYTES];
			if (i >= OFS_DST_ADDR && i < OFS_TYPE)
				return frame_mem[i - ADDR_BYTES];
			if (i == OFS_TYPE)
				return TYPE_ECHO_REP;
			if (i == OFS_CKS_HI)
				return reply_csum[15:8];
			if (i == OFS_CKS_LO)
				return reply_csum[7:0];
			return frame_mem[i];
		endfunction

		function void note_request(req_t r);
			rsp_t        exp;
			int unsigned idx;
			logic [7:0]  v;
			logic [2:0]  vd;
			logic [31:0] s;

			if (r.opcode == OP_READ) begin
				if (!reply_pending || rd_pos >= n_loaded || rd_pos >= STORE_BYTES)
					return;
				idx = rd_pos;
				exp.out_kind = KIND_BYTE;
				exp.verdict  = VD_REPLY;
				exp.out_byte = reply_at(idx);
				exp.out_last = (idx + 1 >= n_loaded);
				rd_pos = idx + 1;
				if (idx + 1 >= n_loaded)
					reply_pending = 1'b0;
				pending.push_back(exp);
				return;
			end

			// first byte after a closed frame opens a new one
			if (frame_done) begin
				frame_done = 1'b0;
				n_loaded   = 0;
				csum_acc   = '0;
				plen       = '0;
				msg_type   = '0;
				msg_code   = '0;
				reply_csum = '0;
			end
			reply_pending = 1'b0;
			rd_pos        = 0;

			if (n_loaded < STORE_BYTES) begin
				idx = n_loaded;
				frame_mem[idx] = r.data_byte;
				if (idx == OFS_PLEN_HI)
					plen[15:8] = r.data_byte;
				else if (idx == OFS_PLEN_LO)
					plen[7:0] = r.data_byte;
				else if (idx == OFS_TYPE)
					msg_type = r.data_byte;
				else if (idx == OFS_CODE)
					msg_code = r.data_byte;

				if (idx >= OFS_SRC_ADDR && (idx < OFS_TYPE || idx < OFS_TYPE + plen)) begin
					v = r.data_byte;
					if (idx == OFS_TYPE)
						v = TYPE_ECHO_REP;
					else if (idx == OFS_CKS_HI || idx == OFS_CKS_LO)
						v = 8'h00;
					csum_acc += idx[0] ? {24'h0, v} : {16'h0, v, 8'h00};
				end
				n_loaded = idx + 1;
			end else begin
				// oversize: extra bytes are dropped
				n_loaded = STORE_BYTES + 1;
			end

			if (!r.last_in)
				return;

			frame_done = 1'b1;
			if (n_loaded > STORE_BYTES || n_loaded < MIN_FRAME || plen < MIN_PLEN ||
					OFS_TYPE + plen > n_loaded)
				vd = VD_MALFORMED;
			else if (msg_type == TYPE_ECHO_REQ)
				vd = (msg_code != 8'h00) ? VD_BAD_CODE : VD_REPLY;
			else if (msg_type == TYPE_ECHO_REP)
				vd = VD_ECHO_REPLY;
			else
				vd = VD_UNKNOWN;

			if (vd == VD_REPLY) begin
				s = {16'h0, fold16(csum_acc)} + {16'h0, plen} + {16'h0, NH_ICMPV6};
				reply_csum    = ~fold16(s);
				reply_pending = 1'b1;
				rd_pos        = 0;
			end
			exp.out_kind = KIND_VERDICT;
			exp.verdict  = vd;
			exp.out_byte = 8'h00;
			exp.out_last = 1'b0;
			pending.push_back(exp);
			n_verdicts++;
		endfunction

		function void flag_error(string msg);
			n_errors++;
			if (n_errors <= REPORT_MAX)
				$display("MISMATCH: %s", msg);
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp;

			if (pending.size() == 0) begin
				flag_error($sformatf("unexpected result kind=%0d verdict=%0d byte=%02h last=%0d",
					got.out_kind, got.verdict, got.out_byte, got.out_last));
				return;
			end
			exp = pending.pop_front();
			if (got.out_kind !== exp.out_kind || got.verdict !== exp.verdict ||
					got.out_byte !== exp.out_byte || got.out_last !== exp.out_last)
				flag_error($sformatf({"exp kind=%0d verdict=%0d byte=%02h last=%0d, ",
					"got kind=%0d verdict=%0d byte=%02h last=%0d"},
					exp.out_kind, exp.verdict, exp.out_byte, exp.out_last,
					got.out_kind, got.verdict, got.out_byte, got.out_last));
		endfunction
	endclass

endpackage

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
	import icer_pkg::*;
	import icer_sb_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS   = 340;
	localparam int unsigned PHASE_FRAMES  = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	req_t        req;
	logic        busy;
	logic        rsp_valid;
	rsp_t        rsp;
	logic        own_mac_we;
	logic [47:0] own_mac_wdata;

	echo_scoreboard sb;
	int unsigned    cycle_cnt  = 0;
	int unsigned    idle_pct   = 0;
	int unsigned    items_sent = 0;

	icmpv6_echo_responder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req           (req),
		.busy          (busy),
		.rsp_valid     (rsp_valid),
		.rsp           (rsp),
		.own_mac_we    (own_mac_we),
		.own_mac_wdata (own_mac_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("icmpv6_echo_responder regression: fail");
			$finish;
		end
	end

	// all sampling here sees pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (own_mac_we)
				sb.set_mac(own_mac_wdata);
			if (start && !busy)
				sb.note_request(req);
			if (rsp_valid)
				sb.check_result(rsp);
		end
	end

	task automatic issue(input logic op, input logic [7:0] data, input logic last);
		req_t r;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		r.opcode    = op;
		r.data_byte = data;
		r.last_in   = last;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_frame(input byte_q_t f);
		foreach (f[i])
			issue(OP_LOAD, f[i], i == f.size() - 1);
		items_sent += f.size();
	endtask

	task automatic read_bytes(input int unsigned n);
		repeat (n)
			issue(OP_READ, 8'($urandom), 1'($urandom));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mac(input logic [47:0] value);
		wait_drained();
		own_mac_we    <= 1'b1;
		own_mac_wdata <= value;
		@(posedge clk);
		own_mac_we <= 1'b0;
	endtask

	// random-content IPv6/ICMPv6 frame, cut to total bytes
	function automatic byte_q_t build_frame(int unsigned total, logic [15:0] plen,
			logic [7:0] ty, logic [7:0] cd);
		byte_q_t     f;
		int unsigned n;
		n = (total < 58) ? 58 : total;
		for (int unsigned i = 0; i < n; i++)
			f.push_back(8'($urandom));
		f[OFS_ETYPE]     = 8'h86;
		f[OFS_ETYPE + 1] = 8'hdd;
		f[14]            = 8'h60;
		f[OFS_PLEN_HI]   = plen[15:8];
		f[OFS_PLEN_LO]   = plen[7:0];
		f[20]            = NH_ICMPV6[7:0];
		f[21]            = 8'hff;
		f[OFS_TYPE]      = ty;
		f[OFS_CODE]      = cd;
		while (f.size() > total)
			void'(f.pop_back());
		return f;
	endfunction

	task automatic run_directed();
		byte_q_t f;

		read_bytes(2);                          // nothing loaded yet

		f = build_frame(62, 8, TYPE_ECHO_REQ, 8'h00);
		send_frame(f);
		read_bytes(64);                         // two reads past the end

		// odd length with trailer, all-ones message body
		f = build_frame(66, 9, TYPE_ECHO_REQ, 8'h00);
		for (int i = OFS_CKS_HI; i < 66; i++)
			f[i] = 8'hff;
		send_frame(f);
		read_bytes(66);

		// all-zero addresses and body
		f = build_frame(62, 8, TYPE_ECHO_REQ, 8'h00);
		for (int i = OFS_SRC_ADDR; i < 62; i++)
			if (i != OFS_TYPE)
				f[i] = 8'h00;
		send_frame(f);
		read_bytes(62);

		send_frame(build_frame(62, 8, TYPE_ECHO_REQ, 8'hff));
		read_bytes(1);
		send_frame(build_frame(64, 10, TYPE_ECHO_REP, 8'h00));
		read_bytes(1);
		send_frame(build_frame(62, 8, 8'h00, 8'h00));
		send_frame(build_frame(62, 8, 8'hff, 8'h00));

		// malformed: short, single byte, tiny length, length past end
		send_frame(build_frame(61, 8, TYPE_ECHO_REQ, 8'h00));
		send_frame(build_frame(1, 8, TYPE_ECHO_REQ, 8'h00));
		send_frame(build_frame(70, 7, TYPE_ECHO_REQ, 8'h00));
		send_frame(build_frame(70, 20, TYPE_ECHO_REQ, 8'h00));
		send_frame(build_frame(80, 16'hffff, TYPE_ECHO_REQ, 8'h00));
		read_bytes(1);

		// one byte over the buffer, then the largest frame that fits
		send_frame(build_frame(STORE_BYTES + 1, 16'(STORE_BYTES + 1 - OFS_TYPE),
			TYPE_ECHO_REQ, 8'h00));
		send_frame(build_frame(STORE_BYTES, 16'(STORE_BYTES - OFS_TYPE),
			TYPE_ECHO_REQ, 8'h00));
		read_bytes(STORE_BYTES);

		// a new load cancels a half-read reply
		send_frame(build_frame(70, 16, TYPE_ECHO_REQ, 8'h00));
		read_bytes(10);
		send_frame(build_frame(62, 8, TYPE_ECHO_REQ, 8'h00));
		read_bytes(63);
	endtask

	task automatic random_frame();
		byte_q_t     f;
		int unsigned pick, plen, trailer, total, nread;
		logic [7:0]  ty, cd;
		bit          good;

		pick    = $urandom_range(99);
		plen    = ($urandom_range(9) == 0) ? $urandom_range(8, 400) : $urandom_range(8, 40);
		trailer = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 0;
		ty      = TYPE_ECHO_REQ;
		cd      = 8'h00;
		good    = 1'b0;
		total   = OFS_TYPE + plen + trailer;

		if (pick < 64) begin
			good = 1'b1;
		end else if (pick < 70) begin
			cd = 8'($urandom_range(1, 255));
		end else if (pick < 76) begin
			ty = TYPE_ECHO_REP;
		end else if (pick < 82) begin
			ty = 8'($urandom);
			if (ty == TYPE_ECHO_REQ || ty == TYPE_ECHO_REP)
				ty = ~ty;
		end else if (pick < 88) begin
			total = $urandom_range(1, MIN_FRAME - 1);
		end else if (pick < 94) begin
			plen  = $urandom_range(0, MIN_PLEN - 1);
			total = OFS_TYPE + MIN_PLEN + $urandom_range(0, 8);
		end else begin
			total = OFS_TYPE + plen - $urandom_range(1, 8);
		end

		if ($urandom_range(19) == 0)
			read_bytes(1);                      // stray read
		f = build_frame(total, 16'(plen), ty, cd);
		send_frame(f);

		if (good) begin
			pick = $urandom_range(9);
			if (pick < 7)
				nread = total + $urandom_range(0, 2);
			else if (pick == 7)
				nread = $urandom_range(1, total - 1);
			else
				nread = 0;
			read_bytes(nread);
			items_sent += (nread < total) ? nread : total;
		end else if ($urandom_range(3) == 0) begin
			read_bytes($urandom_range(1, 2));
		end
	endtask

	task automatic run_random(input int unsigned item_goal, input int unsigned frame_goal);
		int unsigned items0, frames0;
		items0  = items_sent;
		frames0 = sb.n_verdicts;
		while (items_sent - items0 < item_goal || sb.n_verdicts - frames0 < frame_goal)
			random_frame();
	endtask

	initial begin
		int unsigned idle_sched[3];

		idle_sched = '{0, 55, 27};
		sb = new();
		arst_n        = 1'b0;
		start         = 1'b0;
		req           = '0;
		own_mac_we    = 1'b0;
		own_mac_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_mac(48'h0);
		run_directed();
		write_mac(48'hffff_ffff_ffff);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = idle_sched[ph];
			run_random(PHASE_ITEMS, PHASE_FRAMES);
			idle_pct = 0;
			case (ph)
				0: write_mac({$urandom, 16'($urandom)});
				1: write_mac(48'h5555_5555_5555);
				default: write_mac(48'haaaa_aaaa_aaaa);
			endcase
		end
		run_random(40, 1);

		wait_drained();
		if (sb.n_errors == 0 && sb.pending.size() == 0) begin
			$display("icmpv6_echo_responder regression: pass");
		end else begin
			$display("icmpv6_echo_responder regression: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/icer_pkg.sv
hw/rtl/icer_ram.sv
hw/rtl/icer_front.sv
hw/rtl/icer_back.sv
hw/rtl/icmpv6_echo_responder.sv
sim/icer_sb_pkg.sv
sim/tb.sv
